[rtl/core/assert_macros.svh]
// Assertion macros for the slot-window receiver, empty under synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/core/dmxswr_pkg.sv]
// Constants and types for the slot-window receiver
`default_nettype none
package dmxswr_pkg;
   localparam int ByteWidth         = 8;
   localparam int StartAddressWidth = 10;
   localparam int StartCodeWidth    = 8;
   localparam int SlotCountWidth    = 10;
   localparam int SlotSumWidth      = SlotCountWidth + 1;
   localparam int WindowSlots       = 16;
   localparam int OffsetWidth       = 4;
   localparam int MaxSlot           = 512;
   localparam int CsrDataWidth      = 10;
   localparam int CsrIndexWidth     = 1;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_START_ADDRESS = 1'b0,
      CSR_START_CODE    = 1'b1
   } csr_index_type;
endpackage
`default_nettype wire

[rtl/core/dmx512_slot_window_receiver.sv]
// Slot-window receiver: frame tracking, window test and registered result
// The result of an accepted item is registered and shows on the rsp_ side in the next cycle.
// Throughput: one item per cycle; the single result register sets the pace,
// and a new item enters whenever that register is empty or being taken.
// Reset (synchronous, active high): await break and start code, slot count 1,
// start address 1, start code 0, no result held.
`default_nettype none
`include "assert_macros.svh"
module dmx512_slot_window_receiver (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_write_enable,
   input  wire logic [dmxswr_pkg::CsrIndexWidth-1:0]   csr_index,
   input  wire logic [dmxswr_pkg::CsrDataWidth-1:0]    csr_write_data,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic [dmxswr_pkg::ByteWidth-1:0]       req_rx_byte,
   input  wire logic                                   req_overrun_error,
   input  wire logic                                   req_framing_error,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic                                        rsp_slot_write,
   output logic [dmxswr_pkg::OffsetWidth-1:0]          rsp_slot_offset,
   output logic [dmxswr_pkg::ByteWidth-1:0]            rsp_slot_value,
   output logic                                        rsp_frame_complete,
   output logic                                        rsp_port_reset,
   output logic                                        rsp_data_activity
);
   logic [dmxswr_pkg::StartAddressWidth-1:0] start_address_ff;
   logic [dmxswr_pkg::StartCodeWidth-1:0]    start_code_ff;
   logic                                     await_break_ff, await_break_in;
   logic                                     await_start_code_ff, await_start_code_in;
   logic [dmxswr_pkg::SlotCountWidth-1:0]    slot_counter_ff, slot_counter_in;
   logic                                     rsp_valid_ff, rsp_valid_in;
   logic                                     slot_write_ff, slot_write_in;
   logic [dmxswr_pkg::OffsetWidth-1:0]       slot_offset_ff, slot_offset_in;
   logic [dmxswr_pkg::ByteWidth-1:0]         slot_value_ff, slot_value_in;
   logic                                     frame_complete_ff, frame_complete_in;
   logic                                     port_reset_ff, port_reset_in;
   logic                                     data_activity_ff, data_activity_in;
   logic                                     req_accept;
   logic [dmxswr_pkg::SlotSumWidth-1:0]      win_end;
   logic [dmxswr_pkg::SlotSumWidth-1:0]      slot_plus;
   logic [dmxswr_pkg::SlotCountWidth-1:0]    slot_diff;
   logic                                     in_window;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   assign win_end   = {1'b0, start_address_ff}
                      + dmxswr_pkg::SlotSumWidth'(dmxswr_pkg::WindowSlots);
   assign slot_plus = {1'b0, slot_counter_ff} + dmxswr_pkg::SlotSumWidth'(1);
   assign slot_diff = slot_counter_ff - start_address_ff;
   assign in_window = (slot_counter_ff >= start_address_ff)
                      && ({1'b0, slot_counter_ff} < win_end);

   always_comb begin
      await_break_in      = await_break_ff;
      await_start_code_in = await_start_code_ff;
      slot_counter_in     = slot_counter_ff;
      slot_write_in       = 1'b0;
      slot_offset_in      = '0;
      slot_value_in       = '0;
      frame_complete_in   = 1'b0;
      port_reset_in       = 1'b0;
      data_activity_in    = 1'b0;
      priority if (req_overrun_error) begin
         port_reset_in  = 1'b1;
         await_break_in = 1'b1;
      end else if (req_framing_error) begin
         if (req_rx_byte == '0) begin
            await_break_in      = 1'b0;
            await_start_code_in = 1'b1;
            slot_counter_in     = dmxswr_pkg::SlotCountWidth'(1);
         end else begin
            port_reset_in  = 1'b1;
            await_break_in = 1'b1;
         end
      end else if (await_start_code_ff) begin
         if (req_rx_byte == start_code_ff) begin
            await_start_code_in = 1'b0;
         end else begin
            await_break_in = 1'b1;
         end
      end else if (!await_break_ff) begin
         data_activity_in = 1'b1;
         if (in_window) begin
            slot_write_in  = 1'b1;
            slot_offset_in = slot_diff[dmxswr_pkg::OffsetWidth-1:0];
            slot_value_in  = req_rx_byte;
         end
         frame_complete_in = (slot_plus == win_end);
         slot_counter_in   = slot_plus[dmxswr_pkg::SlotCountWidth-1:0];
         if (slot_counter_in > dmxswr_pkg::SlotCountWidth'(dmxswr_pkg::MaxSlot)) begin
            await_break_in = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_address_ff <= dmxswr_pkg::StartAddressWidth'(1);
         start_code_ff    <= '0;
      end else if (csr_write_enable) begin
         unique case (dmxswr_pkg::csr_index_type'(csr_index))
            dmxswr_pkg::CSR_START_ADDRESS: begin
               start_address_ff <= csr_write_data[dmxswr_pkg::StartAddressWidth-1:0];
            end
            dmxswr_pkg::CSR_START_CODE: begin
               start_code_ff <= csr_write_data[dmxswr_pkg::StartCodeWidth-1:0];
            end
            default: begin
               start_code_ff <= start_code_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         await_break_ff      <= 1'b1;
         await_start_code_ff <= 1'b1;
         slot_counter_ff     <= dmxswr_pkg::SlotCountWidth'(1);
         rsp_valid_ff        <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            await_break_ff      <= await_break_in;
            await_start_code_ff <= await_start_code_in;
            slot_counter_ff     <= slot_counter_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         slot_write_ff     <= slot_write_in;
         slot_offset_ff    <= slot_offset_in;
         slot_value_ff     <= slot_value_in;
         frame_complete_ff <= frame_complete_in;
         port_reset_ff     <= port_reset_in;
         data_activity_ff  <= data_activity_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_slot_write     = slot_write_ff;
   assign rsp_slot_offset    = slot_offset_ff;
   assign rsp_slot_value     = slot_value_ff;
   assign rsp_frame_complete = frame_complete_ff;
   assign rsp_port_reset     = port_reset_ff;
   assign rsp_data_activity  = data_activity_ff;

   `ASSERT_IMPLIES(a_write_is_activity, clock, reset,
      rsp_valid_ff && slot_write_ff, data_activity_ff)
   `ASSERT_IMPLIES(a_reset_excludes_activity, clock, reset,
      rsp_valid_ff && port_reset_ff, !data_activity_ff)
   `ASSERT_NEXT(a_overrun_awaits_break, clock, reset,
      req_accept && req_overrun_error, await_break_ff)
   `ASSERT_NEXT(a_break_restarts_count, clock, reset,
      req_accept && !req_overrun_error && req_framing_error && req_rx_byte == '0,
      slot_counter_ff == dmxswr_pkg::SlotCountWidth'(1) && await_start_code_ff)
   `ASSERT_IMPLIES(a_counter_bounded, clock, reset, 1'b1,
      slot_counter_ff <= dmxswr_pkg::SlotCountWidth'(dmxswr_pkg::MaxSlot + 1))
endmodule
`default_nettype wire

[test/tb_dmx512_slot_window_receiver.sv]
// Testbench for the DMX512 slot-window receiver: frame sequencing, window slots, random traffic
`timescale 1ns / 100ps
module tb_dmx512_slot_window_receiver;

   typedef struct packed {
      logic                               slot_write;
      logic [dmxswr_pkg::OffsetWidth-1:0] slot_offset;
      logic [dmxswr_pkg::ByteWidth-1:0]   slot_value;
      logic                               frame_complete;
      logic                               port_reset;
      logic                               data_activity;
   } slot_result_type;

   logic                                       clock = 1'b0;
   logic                                       reset;
   logic                                       csr_write_enable;
   logic [dmxswr_pkg::CsrIndexWidth-1:0]       csr_index;
   logic [dmxswr_pkg::CsrDataWidth-1:0]        csr_write_data;
   logic                                       req_valid;
   logic                                       req_stall;
   logic [dmxswr_pkg::ByteWidth-1:0]           req_rx_byte;
   logic                                       req_overrun_error;
   logic                                       req_framing_error;
   logic                                       rsp_valid;
   logic                                       rsp_stall = 1'b0;
   logic                                       rsp_slot_write;
   logic [dmxswr_pkg::OffsetWidth-1:0]         rsp_slot_offset;
   logic [dmxswr_pkg::ByteWidth-1:0]           rsp_slot_value;
   logic                                       rsp_frame_complete;
   logic                                       rsp_port_reset;
   logic                                       rsp_data_activity;

   // receiver model state and registers
   logic                                       rx_wait_break;
   logic                                       rx_wait_code;
   logic [dmxswr_pkg::SlotCountWidth-1:0]      rx_slot_count;
   logic [dmxswr_pkg::StartAddressWidth-1:0]   cfg_start_address;
   logic [dmxswr_pkg::StartCodeWidth-1:0]      cfg_start_code;

   slot_result_type               slot_results_due[$];
   slot_result_type               due;
   int unsigned                   mismatches;
   int unsigned                   items_sent;
   int unsigned                   req_idle_pct;
   int unsigned                   rsp_stall_pct;
   int unsigned                   drain_cycles;

   dmx512_slot_window_receiver uut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .req_overrun_error  (req_overrun_error),
      .req_framing_error  (req_framing_error),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_slot_write     (rsp_slot_write),
      .rsp_slot_offset    (rsp_slot_offset),
      .rsp_slot_value     (rsp_slot_value),
      .rsp_frame_complete (rsp_frame_complete),
      .rsp_port_reset     (rsp_port_reset),
      .rsp_data_activity  (rsp_data_activity)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
   end

   function automatic slot_result_type predict_slot(
         input logic [dmxswr_pkg::ByteWidth-1:0] rx, input logic ovr, input logic ferr);
      slot_result_type                       res;
      int unsigned                           win_end;
      logic [dmxswr_pkg::SlotCountWidth-1:0] diff;
      res = '0;
      if (ovr) begin
         res.port_reset = 1'b1;
         rx_wait_break  = 1'b1;
      end else if (ferr) begin
         if (rx == '0) begin
            rx_wait_break = 1'b0;
            rx_wait_code  = 1'b1;
            rx_slot_count = dmxswr_pkg::SlotCountWidth'(1);
         end else begin
            res.port_reset = 1'b1;
            rx_wait_break  = 1'b1;
         end
      end else if (rx_wait_code) begin
         if (rx == cfg_start_code)
            rx_wait_code = 1'b0;
         else
            rx_wait_break = 1'b1;
      end else if (!rx_wait_break) begin
         win_end = int'(cfg_start_address) + dmxswr_pkg::WindowSlots;
         res.data_activity = 1'b1;
         if (rx_slot_count >= cfg_start_address && int'(rx_slot_count) < win_end) begin
            diff            = rx_slot_count - cfg_start_address;
            res.slot_write  = 1'b1;
            res.slot_offset = diff[dmxswr_pkg::OffsetWidth-1:0];
            res.slot_value  = rx;
         end
         if (int'(rx_slot_count) + 1 == win_end)
            res.frame_complete = 1'b1;
         rx_slot_count = rx_slot_count + 1'b1;
         if (rx_slot_count > dmxswr_pkg::MaxSlot)
            rx_wait_break = 1'b1;
      end
      return res;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (slot_results_due.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual slot_write %0h value %0h",
                        $time, rsp_slot_write, rsp_slot_value);
               mismatches++;
            end else begin
               due = slot_results_due.pop_front();
               check_field("slot_write", 32'(due.slot_write), 32'(rsp_slot_write));
               check_field("slot_offset", 32'(due.slot_offset), 32'(rsp_slot_offset));
               check_field("slot_value", 32'(due.slot_value), 32'(rsp_slot_value));
               check_field("frame_complete", 32'(due.frame_complete),
                           32'(rsp_frame_complete));
               check_field("port_reset", 32'(due.port_reset), 32'(rsp_port_reset));
               check_field("data_activity", 32'(due.data_activity),
                           32'(rsp_data_activity));
            end
         end
         if (req_valid && !req_stall)
            slot_results_due.push_back(predict_slot(req_rx_byte, req_overrun_error,
                                                    req_framing_error));
      end
   end

   task automatic send_byte(input logic [dmxswr_pkg::ByteWidth-1:0] rx, input logic ovr,
                            input logic ferr);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_rx_byte       <= rx;
      req_overrun_error <= ovr;
      req_framing_error <= ferr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic settle;
      req_valid <= 1'b0;
      @(posedge clock);
      while (slot_results_due.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(input dmxswr_pkg::csr_index_type idx,
                            input logic [dmxswr_pkg::CsrDataWidth-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      unique case (idx)
         dmxswr_pkg::CSR_START_ADDRESS:
            cfg_start_address = data[dmxswr_pkg::StartAddressWidth-1:0];
         dmxswr_pkg::CSR_START_CODE:
            cfg_start_code    = data[dmxswr_pkg::StartCodeWidth-1:0];
      endcase
   endtask

   task automatic send_frame;
      int unsigned n;
      int unsigned r;
      if ($urandom_range(0, 99) < 6) begin
         repeat ($urandom_range(1, 3))
            send_byte(dmxswr_pkg::ByteWidth'($urandom_range(0, 255)),
                      $urandom_range(0, 99) < 10, $urandom_range(0, 99) < 20);
      end
      if ($urandom_range(0, 99) < 92)
         send_byte(8'h00, 1'b0, 1'b1);
      if ($urandom_range(0, 99) < 88)
         send_byte(cfg_start_code, 1'b0, 1'b0);
      else
         send_byte(dmxswr_pkg::ByteWidth'($urandom_range(0, 255)), 1'b0, 1'b0);
      n = (cfg_start_address < 48) ? $urandom_range(0, cfg_start_address + 20)
                                   : $urandom_range(0, 40);
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < 2)
            send_byte(dmxswr_pkg::ByteWidth'($urandom_range(0, 255)), 1'b1,
                      1'($urandom_range(0, 1)));
         else if (r < 4)
            send_byte(dmxswr_pkg::ByteWidth'($urandom_range(1, 255)), 1'b0, 1'b1);
         else if (r < 5)
            send_byte(8'h00, 1'b0, 1'b1);
         else
            send_byte(dmxswr_pkg::ByteWidth'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
   endtask

   task automatic test_frame_sequencing;
      // reset defaults: start address 1, start code 0
      send_byte(8'h55, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'hAA, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b1);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'h3C, 1'b1, 1'b0);
      send_byte(8'h11, 1'b0, 1'b0);
      send_byte(8'h00, 1'b1, 1'b1);
      send_byte(8'h00, 1'b0, 1'b1);
      send_byte(8'h01, 1'b0, 1'b0);
      send_byte(8'h22, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b1);
      send_byte(8'h00, 1'b1, 1'b0);
      send_byte(8'h00, 1'b0, 1'b1);
      send_byte(8'h80, 1'b0, 1'b1);
      send_byte(8'h00, 1'b0, 1'b1);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'h5A, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b1);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'hA5, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b1, 1'b1);
   endtask

   task automatic test_universe_end;
      settle();
      write_csr(dmxswr_pkg::CSR_START_ADDRESS, 10'd497);
      write_csr(dmxswr_pkg::CSR_START_CODE, 10'h3CC);
      send_byte(8'h00, 1'b0, 1'b1);
      send_byte(cfg_start_code, 1'b0, 1'b0);
      // run past slot 512 into the wait for the next break
      repeat (516) send_byte(dmxswr_pkg::ByteWidth'($urandom_range(0, 255)), 1'b0, 1'b0);
   endtask

   task automatic test_random_frames(input int unsigned target);
      int unsigned first;
      int unsigned block_end;
      logic [dmxswr_pkg::StartCodeWidth-1:0] code;
      first = items_sent;
      while (items_sent - first < target) begin
         settle();
         case ($urandom_range(0, 9))
            0:       write_csr(dmxswr_pkg::CSR_START_ADDRESS, 10'd0);
            1:       write_csr(dmxswr_pkg::CSR_START_ADDRESS, 10'd1023);
            2:       write_csr(dmxswr_pkg::CSR_START_ADDRESS, 10'd512);
            3:       write_csr(dmxswr_pkg::CSR_START_ADDRESS, 10'd1);
            default: write_csr(dmxswr_pkg::CSR_START_ADDRESS,
                               dmxswr_pkg::CsrDataWidth'($urandom_range(1, 40)));
         endcase
         case ($urandom_range(0, 4))
            0:       code = 8'h00;
            1:       code = 8'hFF;
            default: code = dmxswr_pkg::StartCodeWidth'($urandom_range(0, 255));
         endcase
         write_csr(dmxswr_pkg::CSR_START_CODE, {2'($urandom_range(0, 3)), code});
         block_end = items_sent + 60;
         while (items_sent < block_end && items_sent - first < target)
            send_frame();
      end
   endtask

   initial begin
      #10_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      reset             <= 1'b1;
      csr_write_enable  <= 1'b0;
      csr_index         <= dmxswr_pkg::CSR_START_ADDRESS;
      csr_write_data    <= '0;
      req_valid         <= 1'b0;
      req_rx_byte       <= '0;
      req_overrun_error <= 1'b0;
      req_framing_error <= 1'b0;
      rx_wait_break     = 1'b1;
      rx_wait_code      = 1'b1;
      rx_slot_count     = dmxswr_pkg::SlotCountWidth'(1);
      cfg_start_address = dmxswr_pkg::StartAddressWidth'(1);
      cfg_start_code    = '0;
      mismatches        = 0;
      items_sent        = 0;
      req_idle_pct      = 24;
      rsp_stall_pct     = 46;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_frame_sequencing();
      test_random_frames(30);
      req_idle_pct  = 46;
      rsp_stall_pct = 24;
      test_universe_end();
      test_random_frames(30);
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      test_random_frames(30);

      req_valid <= 1'b0;
      drain_cycles = 0;
      @(posedge clock);
      while (slot_results_due.size() != 0 && drain_cycles < 20000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (4) @(posedge clock);
      if (mismatches == 0 && slot_results_due.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/dmxswr_pkg.sv
rtl/core/dmx512_slot_window_receiver.sv
test/tb_dmx512_slot_window_receiver.sv
